// ===== sv/cbm_pkg.sv =====
// cbm_pkg: shared types and constants of the codebook background model.
// Used by cbm_front, cbm_back and codebook_background_model.
`default_nettype none
package cbm_pkg;
	localparam int NUM_PIXELS    = 4096;
	localparam int MAX_ENTRIES   = 8;
	localparam int CHANNEL_COUNT = 3;
	localparam int PIX_W         = $clog2(NUM_PIXELS);
	localparam int EIDX_W        = $clog2(MAX_ENTRIES);
	localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] KIND_LEARN  = 2'd0;
	localparam logic [1:0] KIND_DETECT = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [2:0] REG_LEARN_BOUND = 3'd0;
	localparam logic [2:0] REG_MIN_MOD0    = 3'd1;
	localparam logic [2:0] REG_MIN_MOD1    = 3'd2;
	localparam logic [2:0] REG_MIN_MOD2    = 3'd3;
	localparam logic [2:0] REG_MAX_MOD0    = 3'd4;
	localparam logic [2:0] REG_MAX_MOD1    = 3'd5;
	localparam logic [2:0] REG_MAX_MOD2    = 3'd6;

	typedef enum logic [1:0] {OP_LEARN, OP_DETECT, OP_CLEAR, OP_NONE} op_t;

	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] px;
		logic [2:0][7:0]  chan;
	} item_t;

	typedef struct packed {
		logic [7:0]             learn_bound;
		logic [2:0][8:0]        min_mod;
		logic [2:0][8:0]        max_mod;
	} cfg_t;

	typedef struct packed {
		logic [15:0]     idle;
		logic [15:0]     last;
		logic [2:0][7:0] box_hi;
		logic [2:0][7:0] box_lo;
		logic [2:0][7:0] win_hi;
		logic [2:0][7:0] win_lo;
	} entry_t;

	typedef struct packed {
		logic [15:0]      tcount;
		logic [CNT_W-1:0] ecount;
	} meta_t;

	typedef struct packed {
		logic [3:0]        cleared;
		logic              fg;
		logic              full;
		logic [2:0]        eidx;
	} res_t;
endpackage
`default_nettype wire

// ===== sv/codebook_background_model.sv =====
// codebook_background_model: top level; config registers, front queue, back sequencer.
// Depends on cbm_pkg, cbm_front, cbm_back.
//
// Usage:
//  s_axis carries one pixel item per beat: tuser is the kind (learn, detect,
//  clear), tdata the pixel index and three channel values. m_axis returns
//  exactly one result beat per item, in order.
//  cfg_* writes one register per beat (index 0 learn bound, 1..3 min mods,
//  4..6 max mods); cfg_ready is always high.
//  Each item passes the back sequencer states S_IDLE and S_META, then S_RD and
//  S_EX for each codeword scanned in the pixel's table, then S_FIN; detect stops
//  at the first covering box. One item is processed at a time in the back
//  sequencer, bounded by the single codeword memory port pair.
//  A two-entry queue behind s_axis keeps accepting while a result waits.
//  After reset a clearing pass over all 4096 pixels zeroes the per-pixel counts;
//  s_axis_tready stays low during it. When m_axis stalls, the sequencer holds
//  its finished result and the queue fills, then s_axis_tready drops.
`default_nettype none
module codebook_background_model (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // pixel_index[11:0], chan0, chan1, chan2, pad
	input  wire logic [1:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // entry_index, table_full, is_foreground,
	                                        // cleared_count, pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	cbm_pkg::cfg_t  cfg_q;
	cbm_pkg::item_t head;
	cbm_pkg::res_t  res;
	logic           head_valid, pop, init_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_bound <= 8'd10;
			cfg_q.min_mod     <= {3{9'd20}};
			cfg_q.max_mod     <= {3{9'd20}};
		end else if (cfg_valid) begin
			case (cfg_index)
				cbm_pkg::REG_LEARN_BOUND: cfg_q.learn_bound <= cfg_data[7:0];
				cbm_pkg::REG_MIN_MOD0:    cfg_q.min_mod[0]  <= cfg_data;
				cbm_pkg::REG_MIN_MOD1:    cfg_q.min_mod[1]  <= cfg_data;
				cbm_pkg::REG_MIN_MOD2:    cfg_q.min_mod[2]  <= cfg_data;
				cbm_pkg::REG_MAX_MOD0:    cfg_q.max_mod[0]  <= cfg_data;
				cbm_pkg::REG_MAX_MOD1:    cfg_q.max_mod[1]  <= cfg_data;
				cbm_pkg::REG_MAX_MOD2:    cfg_q.max_mod[2]  <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	cbm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_px(s_axis_tdata[11:0]),
		.in_chan({s_axis_tdata[35:28], s_axis_tdata[27:20], s_axis_tdata[19:12]}),
		.enable(init_done), .head_valid(head_valid), .head(head), .pop(pop)
	);

	cbm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.head_valid(head_valid), .head(head), .pop(pop), .init_done(init_done),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {7'd0, res.cleared, res.fg, res.full, res.eidx};
endmodule
`default_nettype wire

// ===== sv/cbm_ram.sv =====
// cbm_ram: generic simple dual-port RAM, one write port, registered read.
// No dependencies.
`default_nettype none
module cbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/cbm_front.sv =====
// cbm_front: accepts input beats, decodes the kind, queues items for the back end.
// Depends on cbm_pkg.
`default_nettype none
module cbm_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                in_kind,
	input  wire logic [cbm_pkg::PIX_W-1:0] in_px,
	input  wire logic [2:0][7:0]           in_chan,
	input  wire logic                      enable,
	output logic                           head_valid,
	output cbm_pkg::item_t                 head,
	input  wire logic                      pop
);
	cbm_pkg::item_t fifo_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	cbm_pkg::item_t item;
	logic           push;

	always_comb begin
		case (in_kind)
			cbm_pkg::KIND_LEARN:  item.op = cbm_pkg::OP_LEARN;
			cbm_pkg::KIND_DETECT: item.op = cbm_pkg::OP_DETECT;
			cbm_pkg::KIND_CLEAR:  item.op = cbm_pkg::OP_CLEAR;
			default:              item.op = cbm_pkg::OP_NONE;
		endcase
		item.px   = in_px;
		item.chan = in_chan;
	end

	assign in_ready   = enable && (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/cbm_back.sv =====
// cbm_back: per-item sequencer over the pixel codebook memories.
// Depends on cbm_pkg and cbm_ram.
`default_nettype none
module cbm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cbm_pkg::cfg_t  cfg,
	input  wire logic           head_valid,
	input  wire cbm_pkg::item_t head,
	output logic                pop,
	output logic                init_done,
	output logic                res_valid,
	input  wire logic           res_ready,
	output cbm_pkg::res_t       res
);
	localparam int EAW = cbm_pkg::PIX_W + cbm_pkg::EIDX_W;
	localparam logic [cbm_pkg::CNT_W-1:0] MAXC = cbm_pkg::CNT_W'(cbm_pkg::MAX_ENTRIES);

	typedef enum logic [2:0] {S_INIT, S_IDLE, S_META, S_RD, S_EX, S_FIN} state_t;

	state_t                      state_q;
	logic [cbm_pkg::PIX_W-1:0]   init_q;
	cbm_pkg::item_t              item_q;
	logic [cbm_pkg::CNT_W-1:0]   cnt_q, idx_q, k_q;
	logic [cbm_pkg::EIDX_W-1:0]  ch_q;
	logic                        hit_q;
	logic [15:0]                 time_q;
	cbm_pkg::res_t               res_q;
	logic                        res_valid_q;

	logic                        meta_we, meta_re;
	logic [cbm_pkg::PIX_W-1:0]   meta_waddr;
	cbm_pkg::meta_t              meta_wdata, meta_rdata;
	logic                        ent_we, ent_re;
	logic [EAW-1:0]              ent_waddr;
	cbm_pkg::entry_t             ent_wdata, ent_rdata;

	logic [2:0][7:0]             hi, lo;
	logic                        match, covered, keep;
	cbm_pkg::entry_t             e, upd_idle, upd_ch, upd_clr, nw;
	logic [15:0]                 run, tnew, t0;
	logic [8:0]                  hsum;
	logic signed [10:0]          vs, lb_s, hb_s;
	logic                        fin_go, last_ent;
	cbm_pkg::res_t               res_d;
	cbm_pkg::meta_t              meta_fin;

	cbm_ram #(.WIDTH($bits(cbm_pkg::meta_t)), .DEPTH(cbm_pkg::NUM_PIXELS)) u_meta (
		.clk(clk), .wr_en(meta_we), .wr_addr(meta_waddr), .wr_data(meta_wdata),
		.rd_en(meta_re), .rd_addr(head.px), .rd_data(meta_rdata)
	);

	cbm_ram #(.WIDTH($bits(cbm_pkg::entry_t)),
		.DEPTH(cbm_pkg::NUM_PIXELS * cbm_pkg::MAX_ENTRIES)) u_ent (
		.clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
		.rd_en(ent_re), .rd_addr({item_q.px, idx_q[cbm_pkg::EIDX_W-1:0]}),
		.rd_data(ent_rdata)
	);

	assign e         = ent_rdata;
	assign pop       = (state_q == S_IDLE) && head_valid;
	assign meta_re   = pop;
	assign ent_re    = (state_q == S_RD);
	assign init_done = (state_q != S_INIT);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign fin_go    = !res_valid_q || res_ready;
	assign last_ent  = (idx_q + 1'b1) == cnt_q;

	always_comb begin
		t0   = (meta_rdata.ecount == '0) ? 16'd0 : meta_rdata.tcount;
		tnew = (t0 != 16'hFFFF) ? t0 + 16'd1 : t0;
		run  = (time_q >= e.last) ? time_q - e.last : 16'd0;
		match   = 1'b1;
		covered = 1'b1;
		upd_idle = e;
		if (e.idle < run) begin
			upd_idle.idle = run;
		end
		upd_ch      = e;
		upd_ch.last = time_q;
		nw          = '0;
		nw.last     = time_q;
		for (int n = 0; n < 3; n++) begin
			hsum  = {1'b0, item_q.chan[n]} + {1'b0, cfg.learn_bound};
			hi[n] = hsum[8] ? 8'hFF : hsum[7:0];
			lo[n] = (item_q.chan[n] > cfg.learn_bound) ?
				item_q.chan[n] - cfg.learn_bound : 8'd0;
			vs    = $signed({3'b000, item_q.chan[n]});
			lb_s  = $signed({3'b000, e.box_lo[n]}) -
				$signed({{2{cfg.min_mod[n][8]}}, cfg.min_mod[n]});
			hb_s  = $signed({3'b000, e.box_hi[n]}) +
				$signed({{2{cfg.max_mod[n][8]}}, cfg.max_mod[n]});
			nw.win_hi[n] = hi[n];
			nw.win_lo[n] = lo[n];
			nw.box_hi[n] = item_q.chan[n];
			nw.box_lo[n] = item_q.chan[n];
			if (n < cbm_pkg::CHANNEL_COUNT) begin
				if (!(e.win_lo[n] <= item_q.chan[n] && item_q.chan[n] <= e.win_hi[n])) begin
					match = 1'b0;
				end
				if (!(lb_s <= vs && vs <= hb_s)) begin
					covered = 1'b0;
				end
				if (e.box_hi[n] < item_q.chan[n]) begin
					upd_ch.box_hi[n] = item_q.chan[n];
				end else if (e.box_lo[n] > item_q.chan[n]) begin
					upd_ch.box_lo[n] = item_q.chan[n];
				end
				if (e.win_hi[n] < hi[n]) begin
					upd_ch.win_hi[n] = e.win_hi[n] + 8'd1;
				end
				if (e.win_lo[n] > lo[n]) begin
					upd_ch.win_lo[n] = e.win_lo[n] - 8'd1;
				end
			end
		end
		keep         = (e.idle <= {1'b0, time_q[15:1]});
		upd_clr      = e;
		upd_clr.idle = 16'd0;
		upd_clr.last = 16'd0;

		ent_we    = 1'b0;
		ent_waddr = {item_q.px, idx_q[cbm_pkg::EIDX_W-1:0]};
		ent_wdata = upd_idle;
		if (state_q == S_EX) begin
			if (item_q.op == cbm_pkg::OP_LEARN) begin
				ent_we = 1'b1;
				if (!hit_q && match) begin
					ent_wdata = upd_ch;
				end
			end else if (item_q.op == cbm_pkg::OP_CLEAR) begin
				ent_we    = keep;
				ent_waddr = {item_q.px, k_q[cbm_pkg::EIDX_W-1:0]};
				ent_wdata = upd_clr;
			end
		end else if (state_q == S_FIN && item_q.op == cbm_pkg::OP_LEARN && !hit_q &&
			cnt_q < MAXC) begin
			ent_we    = 1'b1;
			ent_waddr = {item_q.px, cnt_q[cbm_pkg::EIDX_W-1:0]};
			ent_wdata = nw;
		end

		res_d    = '0;
		meta_fin = '0;
		case (item_q.op)
			cbm_pkg::OP_LEARN: begin
				meta_fin.tcount = time_q;
				meta_fin.ecount = cnt_q;
				if (hit_q) begin
					res_d.eidx = 3'(ch_q);
				end else if (cnt_q < MAXC) begin
					res_d.eidx      = 3'(cnt_q);
					meta_fin.ecount = cnt_q + 1'b1;
				end else begin
					res_d.full = 1'b1;
				end
			end
			cbm_pkg::OP_DETECT: res_d.fg = !hit_q;
			cbm_pkg::OP_CLEAR: begin
				meta_fin.ecount = k_q;
				res_d.cleared   = 4'(cnt_q - k_q);
			end
			default: res_d = '0;
		endcase

		meta_we    = 1'b0;
		meta_waddr = item_q.px;
		meta_wdata = meta_fin;
		if (state_q == S_INIT) begin
			meta_we    = 1'b1;
			meta_waddr = init_q;
			meta_wdata = '0;
		end else if (state_q == S_FIN && (item_q.op == cbm_pkg::OP_LEARN ||
			item_q.op == cbm_pkg::OP_CLEAR)) begin
			meta_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			item_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			ch_q        <= '0;
			hit_q       <= 1'b0;
			time_q      <= '0;
		end else begin
			if (res_valid_q && res_ready && state_q != S_FIN) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == cbm_pkg::PIX_W'(cbm_pkg::NUM_PIXELS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head_valid) begin
						item_q  <= head;
						state_q <= S_META;
					end
				end
				S_META: begin
					cnt_q  <= meta_rdata.ecount;
					time_q <= (item_q.op == cbm_pkg::OP_LEARN) ? tnew : meta_rdata.tcount;
					idx_q  <= '0;
					k_q    <= '0;
					hit_q  <= 1'b0;
					if (item_q.op == cbm_pkg::OP_NONE || meta_rdata.ecount == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: begin
					idx_q <= idx_q + 1'b1;
					case (item_q.op)
						cbm_pkg::OP_LEARN: begin
							state_q <= last_ent ? S_FIN : S_RD;
							if (!hit_q && match) begin
								hit_q <= 1'b1;
								ch_q  <= idx_q[cbm_pkg::EIDX_W-1:0];
							end
						end
						cbm_pkg::OP_DETECT: begin
							if (covered) begin
								hit_q   <= 1'b1;
								state_q <= S_FIN;
							end else begin
								state_q <= last_ent ? S_FIN : S_RD;
							end
						end
						cbm_pkg::OP_CLEAR: begin
							state_q <= last_ent ? S_FIN : S_RD;
							if (keep) begin
								k_q <= k_q + 1'b1;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					if (fin_go) begin
						res_q       <= res_d;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
